@@ rtl/spf_pkg.sv @@
// ----------------------------------------------------------------------------
// spf_pkg
// Shared constants for the segmented odd smallest-prime-factor sieve.
// ----------------------------------------------------------------------------
package spf_pkg;

    // store geometry
    localparam int unsigned ENTRIES  = 65536;
    localparam int unsigned ADDR_W   = $clog2(ENTRIES);
    localparam int unsigned FACTOR_W = 16;

    // segment bounds and derived widths
    localparam int unsigned SEG_W    = 32;
    localparam int unsigned NUM_W    = SEG_W + 1;   // odd number, low + 2*index
    localparam int unsigned WALK_W   = SEG_W + 2;   // walk position incl. overshoot
    localparam int unsigned IDX_W    = SEG_W + 1;   // entry index before bounds check
    localparam int unsigned DIV_CNT_W = $clog2(SEG_W);

    // item modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_SIEVE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // configuration register indexes (address bit 2)
    localparam logic REG_LOW  = 1'b0;
    localparam logic REG_HIGH = 1'b1;
    localparam int unsigned APB_ADDR_W = 3;

    // reset values
    localparam logic [SEG_W-1:0] LOW_RESET  = 32'd3;
    localparam logic [SEG_W-1:0] HIGH_RESET = 32'd3;

endpackage

@@ rtl/segmented_odd_spf_sieve.sv @@
// ----------------------------------------------------------------------------
// segmented_odd_spf_sieve
// Smallest-factor store over the odd numbers of a segment, filled by a walk of
// each sieving prime through a single synchronous memory.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+------------------------
//  command   | i_mode, i_sieve_prime, i_entry_index      | start & !busy
//  result    | o_odd_number, o_smallest_factor,          | o_result_valid, 1 cycle
//            | o_entry_valid                             |
//  config    | psel, penable, pwrite, paddr, pwdata,     | APB, pready always high
//            | prdata                                    |
//
//  read item: accepted into S_READ, result strobed from the registered output
//  clear item: all 65536 entries, one memory entry zeroed per cycle
//  sieve item: remainder division over the 32 bits of low (one quotient bit per cycle),
//  setup states S_BASE, S_ALIGN and S_INDEX, then one entry per cycle of the walk
//  plus a drain of the last write; a prime with p*p >= high ends in S_BASE, with no walk
//  reset starts a clearing pass over all 65536 entries; busy stays high through it
//  the receiver cannot stall; config is taken at any time
// ----------------------------------------------------------------------------
module segmented_odd_spf_sieve
    import spf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_mode,
    input  logic [15:0]           i_sieve_prime,
    input  logic [15:0]           i_entry_index,
    // result channel
    output logic                  o_result_valid,
    output logic [NUM_W-1:0]      o_odd_number,
    output logic [FACTOR_W-1:0]   o_smallest_factor,
    output logic                  o_entry_valid,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_BASE  = 8'b0000_1000,
        S_ALIGN = 8'b0001_0000,
        S_INDEX = 8'b0010_0000,
        S_WALK  = 8'b0100_0000,
        S_READ  = 8'b1000_0000
    } t_state;

    t_state                r_state;
    logic [SEG_W-1:0]      r_low, r_high;
    logic [ADDR_W-1:0]     r_clr_cnt;
    logic [15:0]           r_prime;
    logic [SEG_W-1:0]      r_pp;
    logic [15:0]           r_rem;
    logic [SEG_W-1:0]      r_div_sh;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic [WALK_W-1:0]     r_m;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_pend_valid;
    logic [ADDR_W-1:0]     r_pend_addr;
    logic [15:0]           r_rd_index;
    logic                  r_rd_ok;
    logic [FACTOR_W-1:0]   r_rd_data;
    logic                  r_out_valid;
    logic [NUM_W-1:0]      r_out_num;
    logic [FACTOR_W-1:0]   r_out_factor;
    logic                  r_out_ok;

    logic [FACTOR_W-1:0]   mem [ENTRIES];

    logic                  accept;
    logic                  cfg_wr;
    logic [SEG_W-1:0]      seg_lo;
    logic [NUM_W-1:0]      seg_cnt;
    logic                  idx_in_seg;
    logic [16:0]           div_trial;
    logic                  walk_go;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [FACTOR_W-1:0]   wr_data;
    logic [WALK_W-1:0]     align_max;
    logic                  prime_ok;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE) || r_pend_valid;
    assign seg_lo = r_low | SEG_W'(1);

    // entry count of the segment and bounds check of the read index
    always_comb begin
        seg_cnt = '0;
        if (r_high > seg_lo) begin
            seg_cnt = NUM_W'(({1'b0, r_high} - {1'b0, seg_lo} + NUM_W'(1)) >> 1);
        end
        idx_in_seg = {{(NUM_W-16){1'b0}}, i_entry_index} < seg_cnt;
    end

    // sieve prime must be odd and at least three
    assign prime_ok = i_sieve_prime[0] && (i_sieve_prime >= 16'd3);

    // one restoring step of low mod p
    assign div_trial = {r_rem, r_div_sh[SEG_W-1]};

    // first multiple: at least p*p, forced odd
    assign align_max = (r_m < WALK_W'(r_pp)) ? WALK_W'(r_pp) : r_m;

    // walk continues while below high and inside the store
    assign walk_go = (r_m < WALK_W'(r_high)) && (r_idx[IDX_W-1:ADDR_W] == '0);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HIGH) ? r_high : r_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= LOW_RESET;
            r_high <= HIGH_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LOW) begin
                r_low <= pwdata;
            end else begin
                r_high <= pwdata;
            end
        end
    end

    // memory port selection
    always_comb begin
        rd_addr = r_idx[ADDR_W-1:0];
        if (accept) begin
            rd_addr = i_entry_index;
        end
        wr_en   = 1'b0;
        wr_addr = r_pend_addr;
        wr_data = r_prime;
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_cnt;
            wr_data = '0;
        end else if (r_pend_valid && (r_rd_data == '0)) begin
            wr_en = 1'b1;
        end
    end

    // factor store, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // control state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_cnt    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_mode)
                            MODE_CLEAR: begin
                                r_clr_cnt <= '0;
                                r_state   <= S_CLEAR;
                            end
                            MODE_SIEVE: begin
                                if (prime_ok) begin
                                    r_state <= S_DIV;
                                end
                            end
                            MODE_READ: begin
                                r_state <= S_READ;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
                    if (r_clr_cnt == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (r_div_cnt == '1) begin
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    if (r_pp >= r_high) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_ALIGN;
                    end
                end
                S_ALIGN: begin
                    r_state <= S_INDEX;
                end
                S_INDEX: begin
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (walk_go) begin
                        r_pend_valid <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_prime    <= i_sieve_prime;
                r_pp       <= SEG_W'(i_sieve_prime) * SEG_W'(i_sieve_prime);
                r_rem      <= '0;
                r_div_sh   <= seg_lo;
                r_div_cnt  <= '0;
                r_rd_index <= i_entry_index;
                r_rd_ok    <= idx_in_seg;
            end
            S_DIV: begin
                if (div_trial >= {1'b0, r_prime}) begin
                    r_rem <= 16'(div_trial - {1'b0, r_prime});
                end else begin
                    r_rem <= div_trial[15:0];
                end
                r_div_sh  <= r_div_sh << 1;
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end
            S_BASE: begin
                // round low up to a multiple of p
                if (r_rem == '0) begin
                    r_m <= WALK_W'(seg_lo);
                end else begin
                    r_m <= WALK_W'(seg_lo) + WALK_W'(r_prime) - WALK_W'(r_rem);
                end
            end
            S_ALIGN: begin
                r_m <= align_max[0] ? align_max : align_max + WALK_W'(r_prime);
            end
            S_INDEX: begin
                r_idx <= IDX_W'((r_m - WALK_W'(seg_lo)) >> 1);
            end
            S_WALK: begin
                // odd multiples step by 2p, entries by p
                r_pend_addr <= r_idx[ADDR_W-1:0];
                r_m         <= r_m + WALK_W'({r_prime, 1'b0});
                r_idx       <= r_idx + IDX_W'(r_prime);
            end
            S_READ: begin
                r_out_num    <= NUM_W'(seg_lo) + NUM_W'({r_rd_index, 1'b0});
                r_out_factor <= r_rd_ok ? r_rd_data : '0;
                r_out_ok     <= r_rd_ok;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_result_valid    = r_out_valid;
    assign o_odd_number      = r_out_num;
    assign o_smallest_factor = r_out_factor;
    assign o_entry_valid     = r_out_ok;

    // result strobe comes only out of the read state
    a_strobe_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == S_READ))
        else $error("result strobe without a read");

    // a pending write is only ever raised from the walk state
    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> $past(r_state == S_WALK))
        else $error("pending write outside the walk");

    // walk writes only into entries that held no factor
    a_write_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && r_state != S_CLEAR) |-> (r_rd_data == '0 && r_pend_valid))
        else $error("walk overwrote a factor");

    // an accepted read always yields a result strobe
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == MODE_READ) |=> ##1 o_result_valid)
        else $error("read transaction lost");

    // no result follows a clear transaction
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == MODE_CLEAR) |=> !o_result_valid)
        else $error("clear produced a result");

endmodule
